>>> rtl/spot_pkg.sv
// shared types and constants for the shape pair overlap test
package spot_pkg;

    // shape kinds as they arrive on the bus
    localparam logic [1:0] KIND_POINT  = 2'd0;
    localparam logic [1:0] KIND_RECT   = 2'd1;
    localparam logic [1:0] KIND_CIRCLE = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    // field widths
    localparam int unsigned POS_W  = 16;
    localparam int unsigned SIZE_W = 15;
    // coordinate differences lie between -98302 and +65535
    localparam int unsigned DIFF_W = 18;
    // product width of two differences
    localparam int unsigned PROD_W = 2 * DIFF_W;
    // a squared difference stays below 2^34
    localparam int unsigned SQ_W   = 35;
    // sum of two squares
    localparam int unsigned SUM_W  = SQ_W + 1;
    // radius or radius sum stays within the size width
    localparam int unsigned RAD_W  = SIZE_W;
    localparam int unsigned RSQ_W  = 2 * RAD_W;

    // kind combination after ordering
    typedef enum logic [2:0] {
        PAIR_NONE,
        PAIR_PP,
        PAIR_PR,
        PAIR_RR,
        PAIR_PC,
        PAIR_RC,
        PAIR_CC
    } t_pair;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
    } t_shape;

    // differences and bounds result handed to the distance stages
    typedef struct packed {
        t_pair                    code;
        logic                     box_hit;
        logic signed [DIFF_W-1:0] dx0;
        logic signed [DIFF_W-1:0] dx1;
        logic signed [DIFF_W-1:0] dy0;
        logic signed [DIFF_W-1:0] dy1;
        logic [RAD_W-1:0]         rad;
    } t_diff;

    // load enables of the distance stages
    typedef struct packed {
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

>>> rtl/spot_dist_cmp.sv
// squaring stage and distance compare stage of the overlap test
module spot_dist_cmp
    import spot_pkg::*;
(
    input  logic      i_clk,
    input  t_stage_en i_en,
    input  t_diff     i_diff,
    output logic      o_hit
);

    logic signed [PROD_W-1:0] n_p_dx0, n_p_dx1, n_p_dy0, n_p_dy1;
    logic [RSQ_W-1:0]         n_rad_sq;

    logic [SQ_W-1:0]  r_sq_dx0, r_sq_dx1, r_sq_dy0, r_sq_dy1;
    logic [RSQ_W-1:0] r_rad_sq;
    t_pair            r_code;
    logic             r_box_hit;

    logic [SUM_W-1:0] sum00, sum11, sum10, sum01, rad_ext;
    logic             in00, in11, in10, in01;
    logic             n_hit;
    logic             r_hit;

    // squares of the four differences and of the radius
    always_comb begin
        n_p_dx0  = PROD_W'(i_diff.dx0) * PROD_W'(i_diff.dx0);
        n_p_dx1  = PROD_W'(i_diff.dx1) * PROD_W'(i_diff.dx1);
        n_p_dy0  = PROD_W'(i_diff.dy0) * PROD_W'(i_diff.dy0);
        n_p_dy1  = PROD_W'(i_diff.dy1) * PROD_W'(i_diff.dy1);
        n_rad_sq = RSQ_W'(i_diff.rad) * RSQ_W'(i_diff.rad);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sq_dx0  <= n_p_dx0[SQ_W-1:0];
            r_sq_dx1  <= n_p_dx1[SQ_W-1:0];
            r_sq_dy0  <= n_p_dy0[SQ_W-1:0];
            r_sq_dy1  <= n_p_dy1[SQ_W-1:0];
            r_rad_sq  <= n_rad_sq;
            r_code    <= i_diff.code;
            r_box_hit <= i_diff.box_hit;
        end
    end

    // corner distances against the squared radius
    always_comb begin
        sum00   = SUM_W'(r_sq_dx0) + SUM_W'(r_sq_dy0);
        sum11   = SUM_W'(r_sq_dx1) + SUM_W'(r_sq_dy1);
        sum10   = SUM_W'(r_sq_dx1) + SUM_W'(r_sq_dy0);
        sum01   = SUM_W'(r_sq_dx0) + SUM_W'(r_sq_dy1);
        rad_ext = SUM_W'(r_rad_sq);
        in00    = sum00 < rad_ext;
        in11    = sum11 < rad_ext;
        in10    = sum10 < rad_ext;
        in01    = sum01 < rad_ext;
    end

    // pick the test that belongs to the pair
    always_comb begin
        case (r_code)
            PAIR_PP, PAIR_PR, PAIR_RR: begin
                n_hit = r_box_hit;
            end
            PAIR_PC, PAIR_CC: begin
                n_hit = in00;
            end
            PAIR_RC: begin
                n_hit = in00 | in11 | in10 | in01;
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

>>> rtl/shape_pair_overlap_test.sv
// overlap test of two point, rectangle or circle shapes, four stage pipeline
// throughput: one pair per cycle while the output is taken; one square per difference in stage 3 sets the stage depth
// each stage loads when it is empty or the next one moves, so bubbles close up under stall
// reset: synchronous active-low i_rst_n clears all stage valid bits, no result is pending
// after reset the block takes a pair in the first cycle
module shape_pair_overlap_test
    import spot_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x_a, pos_y_a, width_a, height_a, pos_x_b, pos_y_b, width_b, height_b, 4 zero bits
    input  logic [127:0] s_axis_tdata,
    // kind_a, kind_b
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // overlap, 7 zero bits
    output logic [7:0]   m_axis_tdata
);

    t_shape shp_a, shp_b, n_p, n_q;
    t_shape r_p, r_q;
    t_pair  n_code, r_code1;

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [DIFF_W-1:0] px1, py1, qx1, qy1, px0, py0, qx0, qy0;
    t_diff     n_diff, r_diff;
    t_stage_en stage_en;
    logic      hit;

    // stage ready chain
    always_comb begin
        rdy4 = !r_v4 || m_axis_tready;
        rdy3 = !r_v3 || rdy4;
        rdy2 = !r_v2 || rdy3;
        rdy1 = !r_v1 || rdy2;
    end

    assign s_axis_tready = rdy1;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // unpack the transaction
    always_comb begin
        shp_a.kind = s_axis_tuser[1:0];
        shp_a.x    = s_axis_tdata[15:0];
        shp_a.y    = s_axis_tdata[31:16];
        shp_a.w    = s_axis_tdata[46:32];
        shp_a.h    = s_axis_tdata[61:47];
        shp_b.kind = s_axis_tuser[3:2];
        shp_b.x    = s_axis_tdata[77:62];
        shp_b.y    = s_axis_tdata[93:78];
        shp_b.w    = s_axis_tdata[108:94];
        shp_b.h    = s_axis_tdata[123:109];
    end

    // stage 1: lower kind first, classify the pair
    always_comb begin
        if (shp_a.kind > shp_b.kind) begin
            n_p = shp_b;
            n_q = shp_a;
        end else begin
            n_p = shp_a;
            n_q = shp_b;
        end
        case ({n_p.kind, n_q.kind})
            {KIND_POINT, KIND_POINT}:   n_code = PAIR_PP;
            {KIND_POINT, KIND_RECT}:    n_code = PAIR_PR;
            {KIND_RECT, KIND_RECT}:     n_code = PAIR_RR;
            {KIND_POINT, KIND_CIRCLE}:  n_code = PAIR_PC;
            {KIND_RECT, KIND_CIRCLE}:   n_code = PAIR_RC;
            {KIND_CIRCLE, KIND_CIRCLE}: n_code = PAIR_CC;
            default:                    n_code = PAIR_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_p     <= n_p;
            r_q     <= n_q;
            r_code1 <= n_code;
        end
    end

    // stage 2: far edges, bounds tests, differences, radius
    always_comb begin
        px0 = DIFF_W'(r_p.x);
        py0 = DIFF_W'(r_p.y);
        qx0 = DIFF_W'(r_q.x);
        qy0 = DIFF_W'(r_q.y);
        px1 = px0 + $signed({3'b000, r_p.w});
        py1 = py0 + $signed({3'b000, r_p.h});
        qx1 = qx0 + $signed({3'b000, r_q.w});
        qy1 = qy0 + $signed({3'b000, r_q.h});

        n_diff.code = r_code1;
        case (r_code1)
            PAIR_PP: n_diff.box_hit = (px0 == qx0) && (py0 == qy0);
            PAIR_PR: n_diff.box_hit = (px0 > qx0) && (px0 < qx1) &&
                                      (py0 > qy0) && (py0 < qy1);
            PAIR_RR: n_diff.box_hit = (px1 > qx0) && (py1 > qy0) &&
                                      (qx1 > px0) && (qy1 > py0);
            default: n_diff.box_hit = 1'b0;
        endcase

        n_diff.dx0 = qx0 - px0;
        n_diff.dy0 = qy0 - py0;
        n_diff.dx1 = qx0 - px1;
        n_diff.dy1 = qy0 - py1;

        // radius is half the diameter, truncated; two circles add radii
        if (r_code1 == PAIR_CC) begin
            n_diff.rad = (r_p.w >> 1) + (r_q.w >> 1);
        end else begin
            n_diff.rad = r_q.w >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_diff <= n_diff;
        end
    end

    // stages 3 and 4: squares, then distance compare into the output register
    always_comb begin
        stage_en.s3 = rdy3;
        stage_en.s4 = rdy4;
    end

    spot_dist_cmp u_dist_cmp (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_diff (r_diff),
        .o_hit  (hit)
    );

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {7'b0000000, hit};

    // an empty output register lets the whole pipeline move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v4 |-> s_axis_tready)
        else $error("input stalled while output register is empty");

    // an accepted transaction lands in stage 1
    a_accept_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted transaction lost at stage 1");

    // a full pipeline under output stall takes nothing
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !m_axis_tready) |-> !s_axis_tready)
        else $error("transaction taken while pipeline is full and stalled");

    // a stage holding data under stall keeps it
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !rdy3) |=> r_v3)
        else $error("stage 3 dropped data under stall");

endmodule

>>> tb/tb_shape_pair_overlap_test.sv
// testbench for the shape pair overlap test: directed table plus random pairs against a predictor
module tb_shape_pair_overlap_test
    import spot_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM       = 1825;
    localparam int QUIET_FROM     = N_RANDOM - 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // one pair of shapes, with a hand-typed overlap where the table gives one
    typedef struct {
        t_shape a;
        t_shape b;
        bit     typed;
        bit     val;
    } t_shape_pair;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // pos_x_a, pos_y_a, width_a, height_a, pos_x_b, pos_y_b, width_b, height_b, 4 zero bits
    logic [127:0] s_axis_tdata;
    // kind_a, kind_b
    logic [3:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // overlap, 7 zero bits
    logic [7:0]   m_axis_tdata;

    logic         idle_on;

    // pairs driven but not yet taken, and overlap values owed by the block
    t_shape_pair  queued_pairs[$];
    logic         overlap_due[$];

    int           failures = 0;
    int           results = 0;
    int           hits = 0;
    int           quiet_cycles = 0;
    bit           combo_seen[4][4];

    shape_pair_overlap_test u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // strict test of a point against a circle, exact squares
    function automatic logic in_circle(longint px, longint py, longint cx, longint cy,
                                       longint r);
        longint dx;
        longint dy;
        dx = cx - px;
        dy = cy - py;
        return (dx * dx + dy * dy) < (r * r);
    endfunction

    // expected overlap of one pair, lower kind tested first
    function automatic logic predict_overlap(t_shape a, t_shape b);
        t_shape p;
        t_shape q;
        longint px, py, pw, ph;
        longint qx, qy, qw, qh;
        longint r;
        logic   hit;
        if (a.kind > b.kind) begin
            p = b;
            q = a;
        end else begin
            p = a;
            q = b;
        end
        px = $signed(p.x);
        py = $signed(p.y);
        pw = p.w;
        ph = p.h;
        qx = $signed(q.x);
        qy = $signed(q.y);
        qw = q.w;
        qh = q.h;
        hit = 1'b0;
        if (p.kind == KIND_POINT && q.kind == KIND_POINT) begin
            hit = (px == qx) && (py == qy);
        end else if (p.kind == KIND_POINT && q.kind == KIND_RECT) begin
            hit = (px > qx) && (px < qx + qw) && (py > qy) && (py < qy + qh);
        end else if (p.kind == KIND_RECT && q.kind == KIND_RECT) begin
            hit = (px + pw > qx) && (py + ph > qy) && (qx + qw > px) && (qy + qh > py);
        end else if (p.kind == KIND_POINT && q.kind == KIND_CIRCLE) begin
            hit = in_circle(px, py, qx, qy, qw / 2);
        end else if (p.kind == KIND_RECT && q.kind == KIND_CIRCLE) begin
            // only the four corners count
            r = qw / 2;
            hit = in_circle(px, py, qx, qy, r) ||
                  in_circle(px + pw, py + ph, qx, qy, r) ||
                  in_circle(px + pw, py, qx, qy, r) ||
                  in_circle(px, py + ph, qx, qy, r);
        end else if (p.kind == KIND_CIRCLE && q.kind == KIND_CIRCLE) begin
            hit = in_circle(px, py, qx, qy, pw / 2 + qw / 2);
        end
        return hit;
    endfunction

    function automatic t_shape shp(logic [1:0] kind, int x, int y, int w, int h);
        t_shape s;
        s.kind = kind;
        s.x    = 16'(x);
        s.y    = 16'(y);
        s.w    = 15'(w);
        s.h    = 15'(h);
        return s;
    endfunction

    function automatic logic [1:0] random_kind();
        if ($urandom_range(0, 11) == 0) begin
            return KIND_NONE;
        end
        return 2'($urandom_range(0, 2));
    endfunction

    // mostly shapes close together with modest sizes, some spread over the whole range
    function automatic t_shape_pair random_pair();
        t_shape_pair p;
        logic [15:0] bx;
        logic [15:0] by;
        int          mode;
        int          spread;
        int          span;
        mode     = $urandom_range(0, 9);
        p.a.kind = random_kind();
        p.b.kind = random_kind();
        if (mode < 7) begin
            spread = (mode == 6) ? 20000 : 200;
            span   = (mode == 6) ? 32767 : 300;
            bx     = 16'($urandom);
            by     = 16'($urandom);
            p.a.x  = bx;
            p.a.y  = by;
            p.b.x  = bx + 16'($urandom_range(0, 2 * spread) - spread);
            p.b.y  = by + 16'($urandom_range(0, 2 * spread) - spread);
            p.a.w  = 15'($urandom_range(0, span));
            p.a.h  = 15'($urandom_range(0, span));
            p.b.w  = 15'($urandom_range(0, span));
            p.b.h  = 15'($urandom_range(0, span));
        end else begin
            p.a.x = 16'($urandom);
            p.a.y = 16'($urandom);
            p.b.x = 16'($urandom);
            p.b.y = 16'($urandom);
            p.a.w = 15'($urandom);
            p.a.h = 15'($urandom);
            p.b.w = 15'($urandom);
            p.b.h = 15'($urandom);
        end
        p.typed = 1'b0;
        p.val   = 1'b0;
        return p;
    endfunction

    // put one pair on the input bus, with an occasional gap ahead of it
    task automatic send_pair(input t_shape_pair pr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        queued_pairs = {queued_pairs, pr};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, pr.b.h, pr.b.w, pr.b.y, pr.b.x,
                          pr.a.h, pr.a.w, pr.a.y, pr.a.x};
        s_axis_tuser  <= {pr.b.kind, pr.a.kind};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // result side back-pressure
    initial begin : sink
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // scoreboard and watchdog, bus values sampled as they were before the edge
    always @(posedge i_clk) begin : scoreboard
        t_shape_pair pr;
        logic        want;
        logic [1:0]  lo;
        logic [1:0]  hi;
        if (i_rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                quiet_cycles = 0;
                if (overlap_due.size() == 0) begin
                    $error("overlap: no result expected, got %0b", m_axis_tdata[0]);
                    failures = failures + 1;
                end else begin
                    want = overlap_due.pop_front();
                    if (m_axis_tdata[0] !== want) begin
                        $error("overlap: expected %0b, got %0b", want, m_axis_tdata[0]);
                        failures = failures + 1;
                    end
                    results = results + 1;
                    if (want) begin
                        hits = hits + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                quiet_cycles = 0;
                pr   = queued_pairs.pop_front();
                want = pr.typed ? pr.val : predict_overlap(pr.a, pr.b);
                overlap_due = {overlap_due, want};
                lo = (pr.a.kind < pr.b.kind) ? pr.a.kind : pr.b.kind;
                hi = (pr.a.kind < pr.b.kind) ? pr.b.kind : pr.a.kind;
                combo_seen[lo][hi] = 1'b1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles without a transaction", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // reset, directed table, random pairs, drain and verdict
    initial begin : stimulus
        t_shape_pair table_rows[$];
        int          combos;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        idle_on       <= 1'b1;

        // point pairs, kind none, strict rectangle bounds
        table_rows = {table_rows, t_shape_pair'{shp(KIND_POINT, 0, 0, 0, 0),
                                  shp(KIND_POINT, 0, 0, 0, 0), 1'b1, 1'b1}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_POINT, -32768, 32767, 32767, 32767),
                                  shp(KIND_POINT, -32768, 32767, 0, 0), 1'b1, 1'b1}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_POINT, 32767, -32768, 0, 0),
                                  shp(KIND_POINT, 32767, -32767, 0, 0), 1'b1, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_NONE, 0, 0, 10, 10),
                                  shp(KIND_POINT, 0, 0, 0, 0), 1'b1, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_RECT, 0, 0, 10, 10),
                                  shp(KIND_NONE, 5, 5, 32767, 32767), 1'b1, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_NONE, -1, -1, 32767, 32767),
                                  shp(KIND_NONE, -1, -1, 32767, 32767), 1'b1, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_POINT, 5, 5, 0, 0),
                                  shp(KIND_RECT, 0, 0, 10, 10), 1'b1, 1'b1}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_POINT, 0, 5, 0, 0),
                                  shp(KIND_RECT, 0, 0, 10, 10), 1'b1, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_RECT, 0, 0, 10, 10),
                                  shp(KIND_POINT, 9, 9, 0, 0), 1'b1, 1'b1}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_RECT, 0, 0, 10, 10),
                                  shp(KIND_RECT, 10, 0, 10, 10), 1'b1, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_RECT, 0, 0, 10, 10),
                                  shp(KIND_RECT, 9, 9, 5, 5), 1'b0, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_RECT, -32768, -32768, 32767, 32767),
                                  shp(KIND_RECT, 32767, 32767, 32767, 32767),
                                  1'b0, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_RECT, -32768, -32768, 32767, 32767),
                                  shp(KIND_RECT, -2, -2, 0, 0), 1'b0, 1'b0}};
        // circles: boundary, circle listed first, zero diameter, extremes
        table_rows = {table_rows, t_shape_pair'{shp(KIND_POINT, 3, 4, 0, 0),
                                  shp(KIND_CIRCLE, 0, 0, 12, 0), 1'b0, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_CIRCLE, 0, 0, 10, 0),
                                  shp(KIND_POINT, 3, 4, 0, 0), 1'b0, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_CIRCLE, 7, 7, 0, 0),
                                  shp(KIND_POINT, 7, 7, 0, 0), 1'b1, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_CIRCLE, 0, 0, 0, 0),
                                  shp(KIND_CIRCLE, 0, 0, 0, 0), 1'b1, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_CIRCLE, 0, 0, 0, 0),
                                  shp(KIND_CIRCLE, 0, 0, 3, 0), 1'b0, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_CIRCLE, -32768, -32768, 32767, 32767),
                                  shp(KIND_CIRCLE, 32767, 32767, 32767, 32767),
                                  1'b0, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_CIRCLE, 0, 0, 32767, 0),
                                  shp(KIND_CIRCLE, 20000, 20000, 32767, 0),
                                  1'b0, 1'b0}};
        // rectangle against circle, corners only
        table_rows = {table_rows, t_shape_pair'{shp(KIND_RECT, -5, -5, 10, 10),
                                  shp(KIND_CIRCLE, 0, 0, 8, 0), 1'b0, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_RECT, 3, 3, 10, 10),
                                  shp(KIND_CIRCLE, 0, 0, 10, 0), 1'b0, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_CIRCLE, 20, 20, 10, 0),
                                  shp(KIND_RECT, 12, 12, 4, 4), 1'b0, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_RECT, 0, 0, 32767, 32767),
                                  shp(KIND_CIRCLE, 32767, 32767, 4, 0), 1'b0, 1'b0}};
        table_rows = {table_rows, t_shape_pair'{shp(KIND_POINT, -32768, -32768, 0, 0),
                                  shp(KIND_CIRCLE, 32767, 32767, 32767, 0),
                                  1'b0, 1'b0}};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i]) begin
            send_pair(table_rows[i]);
        end

        // random pairs, idle phases switched per block, quiet stretch at the end
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == QUIET_FROM) begin
                idle_on <= 1'b0;
            end else if (i < QUIET_FROM && i % 64 == 0) begin
                idle_on <= ($urandom_range(0, 3) != 0);
            end
            send_pair(random_pair());
        end
        s_axis_tvalid <= 1'b0;

        // drain, then look for stray results
        while (overlap_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        combos = 0;
        for (int i = 0; i < 4; i++) begin
            for (int j = i; j < 4; j++) begin
                combos += combo_seen[i][j];
            end
        end
        $display("checked %0d shape pairs, %0d of them overlapping", results, hits);
        $display("%0d of 10 kind combinations seen, with gaps and stalls on both sides",
                 combos);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> shape_pair_overlap_test.f
rtl/spot_pkg.sv
rtl/spot_dist_cmp.sv
rtl/shape_pair_overlap_test.sv
tb/tb_shape_pair_overlap_test.sv
